[rtl/adjacency_list_symmetry_check_macros.svh]
// Assertion macros shared by the symmetry checker RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ADJACENCY_LIST_SYMMETRY_CHECK_MACROS_SVH
`define ADJACENCY_LIST_SYMMETRY_CHECK_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, quiet during reset
`define ALSC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("alsc assertion failed");

// Next-cycle implication, quiet during reset
`define ALSC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("alsc assertion failed");

`else

`define ALSC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ALSC_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[rtl/alsc_pkg.sv]
// Shared types and constants for the adjacency symmetry checker.
// No dependencies; used by every module of the block.
`default_nettype none

package alsc_pkg;

  // Fixed field widths
  localparam int VTX_W       = 6;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;
  localparam int CNT_CFG_W   = 7;
  localparam int CNT_RESET   = 64;

  // One classified entry in the queue between front and back
  typedef struct packed {
    logic [VTX_W-1:0] src;
    logic [VTX_W-1:0] nb;
    logic             fin;
    logic             bad;
  } queue_entry_t;

  // Back-end status seen by the front
  typedef struct packed {
    logic init_busy;
  } back_stat_t;

endpackage

`default_nettype wire

[rtl/alsc_front.sv]
// Front end: accepts entries, range-checks the vertices and queues them.
// Depends on alsc_pkg.
`default_nettype none

module alsc_front #(
  parameter int MAX_VERTICES = 64,
  localparam int CW = $clog2(MAX_VERTICES + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [alsc_pkg::VTX_W-1:0]      in_src,
  input  logic [alsc_pkg::VTX_W-1:0]      in_nb,
  input  logic                            in_fin,
  input  logic [CW-1:0]                   eff_count,
  input  alsc_pkg::back_stat_t            stat,
  output logic                            q_valid,
  output alsc_pkg::queue_entry_t          q_entry,
  input  logic                            q_pop
);
  import alsc_pkg::*;

  localparam int Q_DEPTH = 4;
  localparam int QPW     = $clog2(Q_DEPTH);

  queue_entry_t       q_mem_r [Q_DEPTH];
  logic [QPW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QPW:0]       cnt_r, cnt_nxt;
  logic               push;
  queue_entry_t       new_entry;

  // Classify: a vertex at or above the count is dropped later
  always_comb begin
    new_entry.src = in_src;
    new_entry.nb  = in_nb;
    new_entry.fin = in_fin;
    new_entry.bad = (int'(in_src) >= int'(eff_count)) || (int'(in_nb) >= int'(eff_count));
  end

  assign in_tready = (cnt_r != (QPW+1)'(Q_DEPTH)) && !stat.init_busy;
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_entry   = q_mem_r[rd_ptr_r];

  // Pointer and fill updates
  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + QPW'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + QPW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + (QPW+1)'(1);
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - (QPW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_entry;
    end
  end

endmodule

`default_nettype wire

[rtl/alsc_back.sv]
// Back end: appends entries to the adjacency store, walks the stored edges on the
// final entry up to the first edge without a reverse, holds the result register and clears the degrees.
// Depends on alsc_pkg and the macro header.
`default_nettype none
`include "adjacency_list_symmetry_check_macros.svh"

module alsc_back #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_DEGREE   = 8,
  localparam int CW = $clog2(MAX_VERTICES + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [CW-1:0]                       eff_count,
  input  logic                                q_valid,
  input  alsc_pkg::queue_entry_t              q_entry,
  output logic                                q_pop,
  output alsc_pkg::back_stat_t                stat,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [alsc_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import alsc_pkg::*;

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int DW  = $clog2(MAX_DEGREE + 1);
  localparam int KW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int SAW = VW + KW;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_LOAD,
    ST_CHK_ROW,
    ST_CHK_ROWD,
    ST_CHK_NB,
    ST_CHK_NBD,
    ST_CHK_SCAN,
    ST_RESULT,
    ST_CLR
  } state_t;

  // Memories
  logic [DW-1:0]    deg_mem [MAX_VERTICES];
  logic [VTX_W-1:0] st_mem  [MAX_VERTICES << KW];
  logic [DW-1:0]    deg_rdata_r;
  logic [VTX_W-1:0] st_rdata_r;

  // Memory ports
  logic             deg_we;
  logic [VW-1:0]    deg_waddr, deg_raddr;
  logic [DW-1:0]    deg_wdata;
  logic             st_we;
  logic [SAW-1:0]   st_waddr, st_raddr;
  logic [VTX_W-1:0] st_wdata;

  // Control and payload registers
  state_t           state_r, state_nxt;
  logic             b_valid_r, b_valid_nxt;
  logic [VTX_W-1:0] b_src_r, b_src_nxt;
  logic [VTX_W-1:0] b_nb_r, b_nb_nxt;
  logic             b_fin_r, b_fin_nxt;
  logic             b_bad_r, b_bad_nxt;
  logic             byp_valid_r, byp_valid_nxt;
  logic [VW-1:0]    byp_row_r, byp_row_nxt;
  logic [DW-1:0]    byp_deg_r, byp_deg_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CW-1:0]    i_r, i_nxt;
  logic [DW-1:0]    j_r, j_nxt;
  logic [DW-1:0]    k_r, k_nxt;
  logic [DW-1:0]    deg_i_r, deg_i_nxt;
  logic [DW-1:0]    deg_v_r, deg_v_nxt;
  logic [VTX_W-1:0] v_r, v_nxt;
  logic             res_ok_r, res_ok_nxt;
  logic [VW-1:0]    clr_r, clr_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_und_r, out_und_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic [VW-1:0]    b_row, i_row, v_row;
  logic [DW-1:0]    deg_cur;
  logic             res_load;

  assign b_row = VW'(b_src_r);
  assign i_row = i_r[VW-1:0];
  assign v_row = VW'(v_r);

  // Degree of the loading row, forwarded from last cycle's write
  assign deg_cur = (byp_valid_r && (byp_row_r == b_row)) ? byp_deg_r : deg_rdata_r;

  assign stat.init_busy = (state_r == ST_INIT);
  assign out_tvalid     = out_valid_r;
  assign out_tdata      = {{(OUT_TDATA_W-2){1'b0}}, out_ovf_r, out_und_r};

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    b_valid_nxt   = b_valid_r;
    b_src_nxt     = b_src_r;
    b_nb_nxt      = b_nb_r;
    b_fin_nxt     = b_fin_r;
    b_bad_nxt     = b_bad_r;
    byp_valid_nxt = 1'b0;
    byp_row_nxt   = byp_row_r;
    byp_deg_nxt   = byp_deg_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    deg_i_nxt     = deg_i_r;
    deg_v_nxt     = deg_v_r;
    v_nxt         = v_r;
    res_ok_nxt    = res_ok_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r;
    out_und_nxt   = out_und_r;
    out_ovf_nxt   = out_ovf_r;
    q_pop         = 1'b0;
    res_load      = 1'b0;
    deg_we        = 1'b0;
    deg_waddr     = '0;
    deg_wdata     = '0;
    deg_raddr     = '0;
    st_we         = 1'b0;
    st_waddr      = '0;
    st_wdata      = '0;
    st_raddr      = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_INIT, ST_CLR: begin
        // Zero one degree counter a cycle
        deg_we    = 1'b1;
        deg_waddr = clr_r;
        if (clr_r == VW'(MAX_VERTICES - 1)) begin
          clr_nxt   = '0;
          state_nxt = ST_LOAD;
        end else begin
          clr_nxt = clr_r + VW'(1);
        end
      end

      ST_LOAD: begin
        // Pop the next entry and start its degree read
        q_pop       = q_valid && !(b_valid_r && b_fin_r);
        b_valid_nxt = q_pop;
        if (q_pop) begin
          deg_raddr = VW'(q_entry.src);
          b_src_nxt = q_entry.src;
          b_nb_nxt  = q_entry.nb;
          b_fin_nxt = q_entry.fin;
          b_bad_nxt = q_entry.bad;
        end
        // Append the entry popped last cycle
        if (b_valid_r) begin
          if (b_bad_r || (deg_cur >= DW'(MAX_DEGREE))) begin
            ovf_nxt = 1'b1;
          end else begin
            deg_we        = 1'b1;
            deg_waddr     = b_row;
            deg_wdata     = deg_cur + DW'(1);
            st_we         = 1'b1;
            st_waddr      = {b_row, KW'(deg_cur)};
            st_wdata      = b_nb_r;
            byp_valid_nxt = 1'b1;
            byp_row_nxt   = b_row;
            byp_deg_nxt   = deg_cur + DW'(1);
          end
          if (b_fin_r) begin
            i_nxt     = '0;
            state_nxt = ST_CHK_ROW;
          end
        end
      end

      ST_CHK_ROW: begin
        if (i_r >= eff_count) begin
          res_ok_nxt = 1'b1;
          state_nxt  = ST_RESULT;
        end else begin
          deg_raddr = i_row;
          state_nxt = ST_CHK_ROWD;
        end
      end

      ST_CHK_ROWD: begin
        deg_i_nxt = deg_rdata_r;
        if (deg_rdata_r == '0) begin
          i_nxt     = i_r + CW'(1);
          state_nxt = ST_CHK_ROW;
        end else begin
          j_nxt     = '0;
          st_raddr  = {i_row, {KW{1'b0}}};
          state_nxt = ST_CHK_NB;
        end
      end

      ST_CHK_NB: begin
        // Neighbour v of row i: fetch the degree of row v
        v_nxt     = st_rdata_r;
        deg_raddr = VW'(st_rdata_r);
        state_nxt = ST_CHK_NBD;
      end

      ST_CHK_NBD: begin
        deg_v_nxt = deg_rdata_r;
        k_nxt     = '0;
        if (deg_rdata_r == '0) begin
          res_ok_nxt = 1'b0;
          state_nxt  = ST_RESULT;
        end else begin
          st_raddr  = {v_row, {KW{1'b0}}};
          state_nxt = ST_CHK_SCAN;
        end
      end

      ST_CHK_SCAN: begin
        // Look for i in row v, one slot a cycle
        if (int'(st_rdata_r) == int'(i_r)) begin
          if ((j_r + DW'(1)) == deg_i_r) begin
            i_nxt     = i_r + CW'(1);
            state_nxt = ST_CHK_ROW;
          end else begin
            j_nxt     = j_r + DW'(1);
            st_raddr  = {i_row, KW'(j_r + DW'(1))};
            state_nxt = ST_CHK_NB;
          end
        end else if ((k_r + DW'(1)) == deg_v_r) begin
          res_ok_nxt = 1'b0;
          state_nxt  = ST_RESULT;
        end else begin
          k_nxt    = k_r + DW'(1);
          st_raddr = {v_row, KW'(k_r + DW'(1))};
        end
      end

      ST_RESULT: begin
        // Wait for a free output register
        if (!out_valid_r || out_tready) begin
          res_load      = 1'b1;
          out_valid_nxt = 1'b1;
          out_und_nxt   = res_ok_r;
          out_ovf_nxt   = ovf_r;
          ovf_nxt       = 1'b0;
          clr_nxt       = '0;
          state_nxt     = ST_CLR;
        end
      end

      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      b_valid_r   <= 1'b0;
      byp_valid_r <= 1'b0;
      ovf_r       <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      b_valid_r   <= b_valid_nxt;
      byp_valid_r <= byp_valid_nxt;
      ovf_r       <= ovf_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    b_src_r   <= b_src_nxt;
    b_nb_r    <= b_nb_nxt;
    b_fin_r   <= b_fin_nxt;
    b_bad_r   <= b_bad_nxt;
    byp_row_r <= byp_row_nxt;
    byp_deg_r <= byp_deg_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    k_r       <= k_nxt;
    deg_i_r   <= deg_i_nxt;
    deg_v_r   <= deg_v_nxt;
    v_r       <= v_nxt;
    res_ok_r  <= res_ok_nxt;
    out_und_r <= out_und_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  // Degree counters
  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    deg_rdata_r <= deg_mem[deg_raddr];
  end

  // Neighbour store
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    st_rdata_r <= st_mem[st_raddr];
  end

  `ALSC_ASSERT_IMP(a_pop_in_load, clk, rst_n, q_pop, (state_r == ST_LOAD) && q_valid)
  `ALSC_ASSERT_IMP(a_deg_bound, clk, rst_n, deg_we, deg_wdata <= DW'(MAX_DEGREE))
  `ALSC_ASSERT_IMP(a_scan_bounds, clk, rst_n, state_r == ST_CHK_SCAN, (j_r < deg_i_r) && (k_r < deg_v_r))
  `ALSC_ASSERT_NXT(a_result_then_clear, clk, rst_n, res_load, out_valid_r && (state_r == ST_CLR) && !ovf_r)

endmodule

`default_nettype wire

[rtl/adjacency_list_symmetry_check.sv]
// Adjacency symmetry checker, top level: vertex-count register, front
// end with entry queue, and back end. Depends on alsc_pkg, alsc_front,
// alsc_back.
//
// Usage:
//   in_*  : one adjacency entry per item; tdata holds source vertex and
//           neighbour, tlast marks the final entry of a graph.
//   out_* : one item per graph, sent after the final entry: tdata bit 0
//           is_undirected, bit 1 overflow.
//   cfg_* : cfg_wr_en writes the vertex count; write only while idle.
// Loading takes one item per cycle, while there is room, into a four-deep
// queue; the back end appends one entry per cycle while entries wait, using
// a registered degree read with forwarding. After the final entry the back
// end walks the stored edges up to the first without a reverse: a degree
// read per row; a neighbour fetch, its degree read and a scan of its row per
// edge, on the single read port of each memory. The result then enters the
// output register, and the degree counters are swept while new entries may
// keep filling the queue. Reset: degree clearing with in_tready low.
// A stalled receiver holds the result; the back end waits before loading
// the next result, and the queue fills up to its depth.
`default_nettype none

module adjacency_list_symmetry_check #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_DEGREE   = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // [5:0] source_vertex, [11:6] neighbour_vertex, [15:12] zero
  input  logic [alsc_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                 in_tlast,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [0] is_undirected, [1] overflow, [7:2] zero
  output logic [alsc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_wr_en,
  input  logic [alsc_pkg::CNT_CFG_W-1:0]       cfg_wr_data
);
  import alsc_pkg::*;

  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam logic [CW-1:0] CNT_RST =
    (CNT_RESET > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(CNT_RESET);

  logic [CW-1:0]  cnt_eff_r, cnt_eff_nxt;
  logic           q_valid, q_pop;
  queue_entry_t   q_entry;
  back_stat_t     stat;

  // Vertex count, held clamped to MAX_VERTICES
  assign cnt_eff_nxt = (int'(cfg_wr_data) > MAX_VERTICES) ? CW'(MAX_VERTICES)
                                                          : CW'(cfg_wr_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_eff_r <= CNT_RST;
    end else if (cfg_wr_en) begin
      cnt_eff_r <= cnt_eff_nxt;
    end
  end

  alsc_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_src    (in_tdata[VTX_W-1:0]),
    .in_nb     (in_tdata[2*VTX_W-1:VTX_W]),
    .in_fin    (in_tlast),
    .eff_count (cnt_eff_r),
    .stat      (stat),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop)
  );

  alsc_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_DEGREE   (MAX_DEGREE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .eff_count  (cnt_eff_r),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

[test/adjacency_list_symmetry_check_test.sv]
// Self-checking testbench for the adjacency-list symmetry checker.
// Depends on alsc_pkg and adjacency_list_symmetry_check; predicts each
// graph's verdict and compares every result item against it.
`timescale 1ns / 1ps

module adjacency_list_symmetry_check_test;
  import alsc_pkg::*;

  localparam int MAX_V         = 64;
  localparam int MAX_D         = 8;
  localparam int IDLE_PCT      = 34;
  localparam int SETTLE_CYCLES = 200;     // covers queue drain and degree sweep
  localparam int HOLD_CYCLES   = 500;
  localparam int PHASE_ITEMS   = 160;
  localparam int REPORT_MAX    = 10;
  // Well above a run where every item closes its own graph under full stalls
  localparam int CYCLE_LIMIT   = 5000000;

  typedef struct packed {
    logic [VTX_W-1:0] src;
    logic [VTX_W-1:0] nb;
    logic             fin;
  } adj_entry_t;

  typedef struct packed {
    logic undirected;
    logic overflow;
  } verdict_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  // [5:0] source_vertex, [11:6] neighbour_vertex, [15:12] zero
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // [0] is_undirected, [1] overflow, [7:2] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CNT_CFG_W-1:0]   cfg_wr_data = '0;

  adjacency_list_symmetry_check #(
    .MAX_VERTICES (MAX_V),
    .MAX_DEGREE   (MAX_D)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #1 clk = ~clk;

  // Shadow of the graph being loaded
  logic [CNT_CFG_W-1:0] count_shadow = CNT_CFG_W'(CNT_RESET);
  logic [3:0]           row_fill [MAX_V] = '{default: '0};
  logic [VTX_W-1:0]     row_nbrs [MAX_V*MAX_D];
  logic                 dropped_seen = 1'b0;

  verdict_t   graph_verdicts[$];
  adj_entry_t pending_entries[$];
  adj_entry_t on_offer;
  verdict_t   want_verdict;
  bit         offer_next;
  int         queued_items = 0;
  int         accepted_items = 0;
  int         faults = 0;
  int         cycles = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  logic       calm_window;

  // Long stretch where neither side idles
  assign calm_window = (accepted_items >= 1100) && (accepted_items < 1400);

  function automatic int count_limit(input logic [CNT_CFG_W-1:0] c);
    return (c > MAX_V) ? MAX_V : int'(c);
  endfunction

  function automatic adj_entry_t entry_of(input int s, input int d);
    adj_entry_t e;
    e.src = VTX_W'(s);
    e.nb  = VTX_W'(d);
    e.fin = 1'b0;
    return e;
  endfunction

  task automatic log_fault(input string msg);
    faults++;
    if (faults <= REPORT_MAX) $display("%0t mismatch: %s", $time, msg);
  endtask

  // Append one accepted entry; on the final one, work out the graph's verdict
  task automatic absorb_entry(input adj_entry_t e);
    int       lim;
    int       i;
    int       j;
    int       k;
    int       v;
    bit       symmetric;
    bit       found;
    verdict_t verdict;
    lim = count_limit(count_shadow);
    if (e.src >= lim || e.nb >= lim || row_fill[e.src] >= MAX_D) begin
      dropped_seen = 1'b1;
    end else begin
      row_nbrs[e.src*MAX_D + row_fill[e.src]] = e.nb;
      row_fill[e.src] = row_fill[e.src] + 1'b1;
    end
    if (e.fin) begin
      symmetric = 1'b1;
      for (i = 0; i < lim && symmetric; i++) begin
        for (j = 0; j < row_fill[i] && symmetric; j++) begin
          v = row_nbrs[i*MAX_D + j];
          found = 1'b0;
          for (k = 0; k < row_fill[v]; k++) begin
            if (row_nbrs[v*MAX_D + k] == i) found = 1'b1;
          end
          if (!found) symmetric = 1'b0;
        end
      end
      verdict.undirected = symmetric;
      verdict.overflow   = dropped_seen;
      graph_verdicts.push_back(verdict);
      foreach (row_fill[r]) row_fill[r] = '0;
      dropped_seen = 1'b0;
    end
  endtask

  task automatic push_entry(input int s, input int d, input bit fin);
    adj_entry_t e;
    e = entry_of(s, d);
    e.fin = fin;
    pending_entries.push_back(e);
    queued_items++;
  endtask

  // Mostly well-formed undirected graph in random order, sometimes damaged
  task automatic queue_graph(input int lim, input int pairs, output int n_items);
    adj_entry_t ent[$];
    adj_entry_t e;
    adj_entry_t tmp;
    int         fill [MAX_V];
    int         p;
    int         u;
    int         v;
    int         r;
    int         pick;
    foreach (fill[x]) fill[x] = 0;
    if (lim > 0) begin
      for (p = 0; p < pairs; p++) begin
        u = $urandom_range(lim - 1);
        v = $urandom_range(lim - 1);
        if (u == v && fill[u] < MAX_D) begin
          ent.push_back(entry_of(u, u));
          fill[u]++;
        end else if (u != v && fill[u] < MAX_D && fill[v] < MAX_D) begin
          ent.push_back(entry_of(u, v));
          ent.push_back(entry_of(v, u));
          fill[u]++;
          fill[v]++;
        end
      end
    end
    // damage about one graph in five
    if ($urandom_range(99) < 20) begin
      case ($urandom_range(3))
        0: if (ent.size() > 1) ent.delete($urandom_range(ent.size() - 1));
        1: if (lim > 0) ent.push_back(entry_of($urandom_range(lim - 1), $urandom_range(lim - 1)));
        2: ent.push_back(entry_of($urandom_range(63), $urandom_range(63)));
        default: begin
          if (lim > 0) begin
            r = $urandom_range(lim - 1);
            repeat (MAX_D + 1) ent.push_back(entry_of(r, $urandom_range(lim - 1)));
          end
        end
      endcase
    end
    if (ent.size() == 0) ent.push_back(entry_of($urandom_range(63), $urandom_range(63)));
    for (p = ent.size() - 1; p > 0; p--) begin
      pick = $urandom_range(p);
      tmp = ent[p];
      ent[p] = ent[pick];
      ent[pick] = tmp;
    end
    e = ent.pop_back();
    e.fin = 1'b1;
    ent.push_back(e);
    n_items = ent.size();
    foreach (ent[x]) pending_entries.push_back(ent[x]);
    queued_items += n_items;
  endtask

  // Wait until every item is in and every verdict is out, then let the block settle
  task automatic settle();
    while (accepted_items != queued_items || graph_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input int c);
    settle();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CNT_CFG_W'(c);
    count_shadow = CNT_CFG_W'(c);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Stimulus
  initial begin
    int phase_counts [12];
    int phase_items;
    int lim;
    int pairs;
    int n;
    phase_counts = '{64, 5, 127, 3, 16, 2, 65, 1, 40, 0, 64, 9};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // count above the maximum: extreme vertices, self loop, full row, one-way edge
    write_count(127);
    push_entry(0, 63, 0);
    push_entry(63, 0, 0);
    push_entry(5, 5, 0);
    push_entry(63, 63, 1);
    repeat (MAX_D) push_entry(7, 7, 0);
    push_entry(7, 7, 1);
    push_entry(10, 20, 0);
    push_entry(20, 11, 1);
    // count of three: source and neighbour out of range
    write_count(3);
    push_entry(2, 1, 0);
    push_entry(1, 2, 0);
    push_entry(3, 0, 0);
    push_entry(0, 5, 0);
    push_entry(0, 0, 1);
    // zero count: everything dropped, empty graph
    write_count(0);
    push_entry(0, 0, 1);
    // count lowered mid-graph: row 40 no longer checked
    write_count(64);
    push_entry(40, 41, 0);
    write_count(10);
    push_entry(1, 1, 1);

    // random graphs under a range of counts
    foreach (phase_counts[p]) begin
      write_count(phase_counts[p]);
      lim = count_limit(CNT_CFG_W'(phase_counts[p]));
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if (lim >= 32 && $urandom_range(99) < 3) pairs = $urandom_range(160, 60);
        else pairs = $urandom_range(12, 1);
        queue_graph(lim, pairs, n);
        phase_items += n;
      end
    end

    settle();
    faults += graph_verdicts.size();
    if (faults == 0) begin
      $display("PASS adjacency_list_symmetry_check");
    end else begin
      $display("FAIL adjacency_list_symmetry_check");
    end
    $finish;
  end

  // Input driver: hold each item until taken, random gaps between items
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      offer_next = in_tvalid;
      if (in_tvalid && in_tready) begin
        absorb_entry(on_offer);
        accepted_items <= accepted_items + 1;
        offer_next = 1'b0;
      end
      if (!offer_next && pending_entries.size() > 0 &&
          (calm_window || hold_left > 0 || $urandom_range(99) >= IDLE_PCT)) begin
        on_offer = pending_entries.pop_front();
        in_tdata <= {{(IN_TDATA_W - 2*VTX_W){1'b0}}, on_offer.nb, on_offer.src};
        in_tlast <= on_offer.fin;
        offer_next = 1'b1;
      end
      in_tvalid <= offer_next;
    end
  end

  // One long receiver hold-off so the entry queue fills and stalls the input
  always @(posedge clk) begin
    if (!hold_done && accepted_items >= 700) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor and receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (graph_verdicts.size() == 0) begin
          log_fault($sformatf("result %b with no graph outstanding", out_tdata[1:0]));
        end else begin
          want_verdict = graph_verdicts.pop_front();
          if (out_tdata[0] !== want_verdict.undirected)
            log_fault($sformatf("is_undirected expected %b got %b",
                                want_verdict.undirected, out_tdata[0]));
          if (out_tdata[1] !== want_verdict.overflow)
            log_fault($sformatf("overflow expected %b got %b",
                                want_verdict.overflow, out_tdata[1]));
        end
      end
      out_tready <= (hold_left == 0) && (calm_window || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL adjacency_list_symmetry_check");
      $finish;
    end
  end

endmodule
